// ===== src/sbt_pkg.sv =====
// shared constants, types and the duplex bit table for the subterranean duplex core
package sbt_pkg;

    localparam int unsigned STATE_W = 257;
    localparam int unsigned IDX_W   = 9;
    localparam int unsigned WORD_W  = 32;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned PAD_POS = 8;

    typedef logic [STATE_W-1:0] state_t;
    typedef logic [WORD_W-1:0]  word_t;
    typedef logic [IDX_W-1:0]   idx_t;

    typedef enum logic [1:0] {
        FUNC_ROUND       = 2'd0,
        FUNC_ABSORB_WORD = 2'd1,
        FUNC_ABSORB_BYTE = 2'd2,
        FUNC_EXTRACT     = 2'd3
    } func_t;

    localparam idx_t DUP_POS [WORD_W] = '{
        9'd1,   9'd176, 9'd136, 9'd35,  9'd249, 9'd134, 9'd197, 9'd234,
        9'd64,  9'd213, 9'd223, 9'd184, 9'd2,   9'd95,  9'd15,  9'd70,
        9'd241, 9'd11,  9'd137, 9'd211, 9'd128, 9'd169, 9'd189, 9'd111,
        9'd4,   9'd190, 9'd30,  9'd140, 9'd225, 9'd22,  9'd17,  9'd165
    };

endpackage

// ===== src/sbt_channels_if.sv =====
// valid/ready channel interfaces for the request and response sides
interface sbt_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [31:0] data_in;

    modport source (output valid, output func, output data_in, input ready);
    modport sink (input valid, input func, input data_in, output ready);
endinterface

interface sbt_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] data_out;

    modport source (output valid, output data_out, input ready);
    modport sink (input valid, input data_out, output ready);
endinterface

// ===== src/sbt_round.sv =====
// one subterranean round: chi, iota, theta and pi over the 257-bit state
module sbt_round
    import sbt_pkg::*;
(
    input  state_t state,
    output state_t round_state
);

    state_t chi_v;
    state_t iota_v;
    state_t theta_v;

    for (genvar i = 0; i < STATE_W; i++)
    begin : g_chi
        localparam int unsigned P1 = (i + 1) % STATE_W;
        localparam int unsigned P2 = (i + 2) % STATE_W;
        assign chi_v[i] = state[i] ^ (~state[P1] & state[P2]);
    end

    always_comb
    begin
        iota_v    = chi_v;
        iota_v[0] = ~chi_v[0];
    end

    for (genvar i = 0; i < STATE_W; i++)
    begin : g_theta
        localparam int unsigned P3 = (i + 3) % STATE_W;
        localparam int unsigned P8 = (i + 8) % STATE_W;
        assign theta_v[i] = iota_v[i] ^ iota_v[P3] ^ iota_v[P8];
    end

    for (genvar i = 0; i < STATE_W; i++)
    begin : g_pi
        localparam int unsigned PS = (12 * i) % STATE_W;
        assign round_state[i] = theta_v[PS];
    end

endmodule

// ===== src/sbt_out_buf.sv =====
// response register: holds one finished word until the receiver takes it
module sbt_out_buf
    import sbt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load,
    input  word_t     load_data,
    output logic      can_load,
    sbt_rsp_if.source rsp
);

    logic  valid_reg;
    logic  valid_next;
    word_t data_reg;
    word_t data_next;

    assign can_load = ~valid_reg | rsp.ready;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (load)
        begin
            valid_next = 1'b1;
            data_next  = load_data;
        end
        else if (rsp.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign rsp.valid    = valid_reg;
    assign rsp.data_out = data_reg;

endmodule

// ===== src/subterranean_duplex_core.sv =====
// top level of the subterranean duplex core
//
// req channel: func and data_in; one transaction is one operation on the
// 257-bit state (round, absorb word, absorb byte with padding, extract).
// rsp channel: data_out; every request gives exactly one response word,
// the extracted word for extract and zero for the other operations.
// the response is registered: it is valid in the cycle after the request transaction.
// one transaction per cycle while no response is stalled; the state register is updated in
// the cycle of the request, so back-to-back operations see each other.
// the round is a single pass of xor/and logic between the state register and itself.
// reset clears the state to all zeros and empties the response register.
// when the receiver stalls, the held response stays stable and req.ready
// drops until it is taken; a new request is taken in the same cycle the
// held response leaves.
module subterranean_duplex_core
    import sbt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    sbt_req_if.sink req,
    sbt_rsp_if.source rsp
);

    state_t state_reg;
    state_t state_next;
    state_t round_state;
    state_t absorb_mask;
    word_t  absorb_word;
    word_t  extract_word;
    word_t  result;
    func_t  func;
    logic   accept;
    logic   can_load;

    assign func   = func_t'(req.func);
    assign accept = req.valid & req.ready;

    sbt_round u_round (
        .state       (state_reg),
        .round_state (round_state)
    );

    for (genvar j = 0; j < WORD_W; j++)
    begin : g_extract
        localparam idx_t MIR = idx_t'(STATE_W - int'(DUP_POS[j]));
        assign extract_word[j] = state_reg[DUP_POS[j]] ^ state_reg[MIR];
    end

    always_comb
    begin
        absorb_mask = '0;
        for (int j = 0; j < WORD_W; j++)
        begin
            absorb_mask[DUP_POS[j]] = absorb_word[j];
        end
    end

    always_comb
    begin
        absorb_word = '0;
        result      = '0;
        state_next  = state_reg;
        unique case (func)
            FUNC_ROUND:
            begin
                state_next = round_state;
            end
            FUNC_ABSORB_WORD:
            begin
                absorb_word = req.data_in;
                state_next  = state_reg ^ absorb_mask;
            end
            FUNC_ABSORB_BYTE:
            begin
                absorb_word[BYTE_W-1:0] = req.data_in[BYTE_W-1:0];
                absorb_word[PAD_POS]    = 1'b1;
                state_next              = state_reg ^ absorb_mask;
            end
            FUNC_EXTRACT:
            begin
                result = extract_word;
            end
            default:
            begin
                state_next = state_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

    sbt_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .load_data (result),
        .can_load  (can_load),
        .rsp       (rsp)
    );

    assign req.ready = can_load;

`ifndef NO_ASSERTIONS
    a_extract_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
        accept && func == FUNC_EXTRACT |=> state_reg == $past(state_reg))
        else $error("extract changed the state");

    a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept && func != FUNC_EXTRACT |=> rsp.valid && rsp.data_out == '0)
        else $error("non-extract response is not zero");

    a_pad_flips: assert property (@(posedge clk) disable iff (!rst_n)
        accept && func == FUNC_ABSORB_BYTE |=>
        state_reg[DUP_POS[PAD_POS]] != $past(state_reg[DUP_POS[PAD_POS]]))
        else $error("byte absorb did not apply padding");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ready |-> !req.ready)
        else $error("request taken while response is stalled");

    a_idle_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> state_reg == $past(state_reg))
        else $error("state changed without a transaction");
`endif

endmodule

// ===== verif/tb.sv =====
// self-checking testbench for subterranean_duplex_core with a bit-level state predictor
`timescale 1ns / 1ps

module tb;
    import sbt_pkg::*;

    typedef struct {
        func_t op;
        word_t data;
        int    gap;
        bit    drain;
    } duplex_op_t;

    logic clk;
    logic rst_n;

    sbt_req_if req_ch();
    sbt_rsp_if rsp_ch();

    subterranean_duplex_core u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    duplex_op_t pending_ops[$];
    word_t      expected_words[$];
    state_t     duplex_st;
    int         n_accepted;
    int         n_mismatch;
    int         idle_cnt;
    int         stall_cnt;
    int         stall_len;
    bit         rsp_quiet;
    logic       hold_off;

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // applies one operation to the predicted state, returns the expected word
    function automatic word_t duplex_op(func_t op, word_t din);
        state_t a;
        state_t b;
        word_t  w;
        w = '0;
        case (op)
            FUNC_ROUND:
            begin
                for (int i = 0; i < STATE_W; i++)
                    a[i] = duplex_st[i] ^ (~duplex_st[(i + 1) % STATE_W]
                                           & duplex_st[(i + 2) % STATE_W]);
                a[0] = ~a[0];
                for (int i = 0; i < STATE_W; i++)
                    b[i] = a[i] ^ a[(i + 3) % STATE_W] ^ a[(i + 8) % STATE_W];
                for (int i = 0; i < STATE_W; i++)
                    duplex_st[i] = b[(12 * i) % STATE_W];
            end
            FUNC_ABSORB_WORD:
            begin
                for (int j = 0; j < WORD_W; j++)
                    duplex_st[DUP_POS[j]] = duplex_st[DUP_POS[j]] ^ din[j];
            end
            FUNC_ABSORB_BYTE:
            begin
                for (int j = 0; j < BYTE_W; j++)
                    duplex_st[DUP_POS[j]] = duplex_st[DUP_POS[j]] ^ din[j];
                duplex_st[DUP_POS[PAD_POS]] = ~duplex_st[DUP_POS[PAD_POS]];
            end
            default:
            begin
                for (int i = 0; i < WORD_W; i++)
                    w[i] = duplex_st[DUP_POS[i]]
                           ^ duplex_st[(STATE_W - DUP_POS[i]) % STATE_W];
            end
        endcase
        return w;
    endfunction

    function automatic void push_op(func_t op, word_t data, int gap, bit drain);
        duplex_op_t t;
        t.op    = op;
        t.data  = data;
        t.gap   = gap;
        t.drain = drain;
        pending_ops.push_back(t);
    endfunction

    function automatic word_t rand_word();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return word_t'(1) << $urandom_range(0, WORD_W - 1);
            default: return $urandom;
        endcase
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid   <= 1'b0;
            req_ch.func    <= FUNC_ROUND;
            req_ch.data_in <= '0;
            idle_cnt = 0;
            n_accepted = 0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                expected_words.push_back(duplex_op(func_t'(req_ch.func), req_ch.data_in));
                void'(pending_ops.pop_front());
                n_accepted++;
                idle_cnt = 0;
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (pending_ops.size() > 0 && idle_cnt >= pending_ops[0].gap
                    && !(pending_ops[0].drain && expected_words.size() > 0))
                begin
                    req_ch.valid   <= 1'b1;
                    req_ch.func    <= pending_ops[0].op;
                    req_ch.data_in <= pending_ops[0].data;
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                    if (pending_ops.size() > 0 && idle_cnt < pending_ops[0].gap)
                        idle_cnt++;
                end
            end
        end
    end

    // response monitor and checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            stall_cnt = 0;
            stall_len = 0;
            rsp_quiet = 1'b0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_words.size() == 0)
                begin
                    if (n_mismatch < 10)
                        $display("unexpected transaction: data_out %08h", rsp_ch.data_out);
                    n_mismatch++;
                end
                else if (rsp_ch.data_out !== expected_words[0])
                begin
                    if (n_mismatch < 10)
                        $display("data_out mismatch: expected %08h actual %08h",
                                 expected_words[0], rsp_ch.data_out);
                    n_mismatch++;
                    void'(expected_words.pop_front());
                end
                else
                    void'(expected_words.pop_front());
                if ($urandom_range(0, 29) == 0)
                    rsp_quiet = ~rsp_quiet;
                stall_len = rsp_quiet ? 0 : $urandom_range(0, 10);
                stall_cnt = 0;
            end
            if (hold_off)
                rsp_ch.ready <= 1'b0;
            else if (stall_cnt < stall_len)
            begin
                stall_cnt++;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    // long receiver hold-offs so the core backs up into its input
    initial
    begin
        hold_off = 1'b0;
        while (n_accepted < 300)
            @(posedge clk);
        hold_off <= 1'b1;
        repeat (150) @(posedge clk);
        hold_off <= 1'b0;
        while (n_accepted < 1000)
            @(posedge clk);
        hold_off <= 1'b1;
        repeat (150) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin
        #400000;
        $display("** subterranean_duplex_core: FAILED **");
        $finish;
    end

    initial
    begin
        int    burst_left;
        bit    no_gap;
        int    gap;
        int    k;
        func_t op;
        rst_n          = 1'b0;
        req_ch.valid   = 1'b0;
        req_ch.func    = FUNC_ROUND;
        req_ch.data_in = '0;
        rsp_ch.ready   = 1'b0;
        duplex_st      = '0;
        n_mismatch     = 0;
        burst_left     = 0;
        no_gap         = 1'b0;

        // directed opening
        push_op(FUNC_EXTRACT,     32'h0000_0000, 0, 1'b0);
        push_op(FUNC_ABSORB_WORD, 32'hffff_ffff, 0, 1'b0);
        push_op(FUNC_EXTRACT,     32'hffff_ffff, 0, 1'b0);
        push_op(FUNC_ROUND,       32'hffff_ffff, 1, 1'b0);
        push_op(FUNC_EXTRACT,     32'h0000_0000, 0, 1'b0);
        push_op(FUNC_ABSORB_WORD, 32'h0000_0000, 0, 1'b0);
        push_op(FUNC_EXTRACT,     32'h1234_5678, 2, 1'b0);
        push_op(FUNC_ABSORB_BYTE, 32'hffff_ff00, 0, 1'b0);
        push_op(FUNC_EXTRACT,     32'h0000_0000, 0, 1'b0);
        push_op(FUNC_ABSORB_BYTE, 32'h0000_00ff, 0, 1'b0);
        push_op(FUNC_EXTRACT,     32'h0000_0000, 0, 1'b0);
        push_op(FUNC_ABSORB_BYTE, 32'hffff_ffff, 3, 1'b0);
        push_op(FUNC_ROUND,       32'h0000_0000, 0, 1'b0);
        push_op(FUNC_ROUND,       32'h0000_0000, 0, 1'b0);
        push_op(FUNC_ROUND,       32'h5555_aaaa, 0, 1'b0);
        push_op(FUNC_EXTRACT,     32'h0000_0000, 0, 1'b0);
        push_op(FUNC_ABSORB_WORD, 32'h8000_0001, 0, 1'b0);
        push_op(FUNC_ABSORB_WORD, 32'h7fff_fffe, 0, 1'b0);
        push_op(FUNC_EXTRACT,     32'hffff_ffff, 0, 1'b0);
        push_op(FUNC_ROUND,       32'h0000_0000, 5, 1'b0);
        push_op(FUNC_EXTRACT,     32'h0000_0000, 0, 1'b0);
        push_op(FUNC_EXTRACT,     32'hdead_beef, 0, 1'b1);

        // random duplex traffic
        for (int n = 0; n < 1530; n++)
        begin
            k = pending_ops.size();
            if (burst_left == 0)
            begin
                no_gap     = ($urandom_range(0, 2) == 0);
                burst_left = $urandom_range(10, 60);
            end
            burst_left--;
            gap = no_gap ? 0 : $urandom_range(0, 10);
            if ((k >= 290 && k < 420) || (k >= 990 && k < 1120))
                gap = 0;
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6: op = FUNC_ROUND;
                7, 8, 9, 10, 11:     op = FUNC_ABSORB_WORD;
                12, 13, 14:          op = FUNC_ABSORB_BYTE;
                default:             op = FUNC_EXTRACT;
            endcase
            push_op(op, rand_word(), gap,
                    (k == 500 || k == 1250 || $urandom_range(0, 199) == 0));
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_ops.size() != 0 || expected_words.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (n_mismatch == 0)
            $display("** subterranean_duplex_core: PASSED **");
        else
            $display("** subterranean_duplex_core: FAILED **");
        $finish;
    end

endmodule
